// File: hw/rtl/srdu_pkg.sv
// ----------------------------------------------------------------------------
// srdu_pkg
// Shared sizes, operation and status codes, and divider handshake types for
// the data stack unit.
// ----------------------------------------------------------------------------
package srdu_pkg;

    localparam int WORD_W      = 32;
    localparam int STACK_DEPTH = 64;
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int OUT_CNT_W   = 7;
    localparam int OP_W        = 3;
    localparam int STAT_W      = 2;
    localparam int DIV_CNT_W   = $clog2(WORD_W);

    // operation codes
    localparam logic [OP_W-1:0] OP_PUSH  = 3'd0;
    localparam logic [OP_W-1:0] OP_POP   = 3'd1;
    localparam logic [OP_W-1:0] OP_DIV   = 3'd2;
    localparam logic [OP_W-1:0] OP_MOD   = 3'd3;
    localparam logic [OP_W-1:0] OP_ROLL  = 3'd4;
    localparam logic [OP_W-1:0] OP_DEPTH = 3'd5;

    // status codes
    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_UNDER = 2'd1;
    localparam logic [STAT_W-1:0] STAT_OVER  = 2'd2;
    localparam logic [STAT_W-1:0] STAT_DIVZ  = 2'd3;

    typedef struct packed {
        logic              start;
        logic [WORD_W-1:0] dividend;
        logic [WORD_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [WORD_W-1:0] quotient;
        logic [WORD_W-1:0] remainder;
    } div_rsp_t;

endpackage

// File: hw/rtl/stack_roll_divide_unit_core.sv
// ----------------------------------------------------------------------------
// stack_roll_divide_unit_core
// Bounded data stack of signed words: push, pop, divide, modulo, roll, depth.
// ----------------------------------------------------------------------------
// Push, depth, failing ops and a pop that empties the stack finish from the
// execute state; other pops first re-read the new top from the stack RAM.
// Divide and modulo read the dividend, then run 32 quotient bits, one per
// cycle in the divider; roll moves one entry per cycle through the stack RAM
// port, then writes the moved item and re-reads the top.
// One item at a time: s_tready is high only while the sequencer is idle; the
// next beat is taken in the cycle its result beat is first offered, and a
// stalled result beat holds the sequencer. Reset clears the entry count and
// control state; stack RAM contents are not cleared and no clearing pass runs.
// ----------------------------------------------------------------------------
module stack_roll_divide_unit_core (
    input  logic        clk,
    input  logic        rst_n,
    // input beats
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] value
    input  logic [2:0]  s_tuser,   // [2:0] operation
    // result beats
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [31:0] top_word, [38:32] item_count, [39] zero
    output logic [2:0]  m_tuser    // [0] top_valid, [2:1] status
);

    localparam int WORD_W = srdu_pkg::WORD_W;
    localparam int ADDR_W = srdu_pkg::ADDR_W;
    localparam int CNT_W  = srdu_pkg::CNT_W;
    localparam int OCW    = srdu_pkg::OUT_CNT_W;

    // sequencer states
    localparam logic [3:0] ST_IDLE     = 4'd0;
    localparam logic [3:0] ST_EXEC     = 4'd1;
    localparam logic [3:0] ST_DIV_RD   = 4'd2;
    localparam logic [3:0] ST_DIV_CAP  = 4'd3;
    localparam logic [3:0] ST_DIV_WAIT = 4'd4;
    localparam logic [3:0] ST_ROLL_RD  = 4'd5;
    localparam logic [3:0] ST_ROLL_CAP = 4'd6;
    localparam logic [3:0] ST_MOVE_RD  = 4'd7;
    localparam logic [3:0] ST_MOVE_WR  = 4'd8;
    localparam logic [3:0] ST_FINAL_WR = 4'd9;
    localparam logic [3:0] ST_TOP_RD   = 4'd10;
    localparam logic [3:0] ST_TOP_CAP  = 4'd11;
    localparam logic [3:0] ST_DONE     = 4'd12;

    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(srdu_pkg::STACK_DEPTH);

    // control and working registers
    logic [3:0]                    state_reg,  state_next;
    logic [srdu_pkg::OP_W-1:0]     op_reg,     op_next;
    logic [WORD_W-1:0]             val_reg,    val_next;
    logic [CNT_W-1:0]              count_reg,  count_next;
    logic [WORD_W-1:0]             top_reg,    top_next;
    logic [srdu_pkg::STAT_W-1:0]   status_reg, status_next;
    logic [WORD_W-1:0]             word_reg,   word_next;
    logic                          popped_reg, popped_next;
    logic [WORD_W-1:0]             tmp_reg,    tmp_next;
    logic [ADDR_W-1:0]             ptr_reg,    ptr_next;
    logic [CNT_W-1:0]              moves_reg,  moves_next;
    logic                          neg_reg,    neg_next;

    // output register
    logic                          m_valid_reg;
    logic [WORD_W-1:0]             m_word_reg;
    logic                          m_flag_reg;
    logic [OCW-1:0]                m_count_reg;
    logic [srdu_pkg::STAT_W-1:0]   m_status_reg;
    logic                          out_load;

    // stack RAM port
    logic                          ram_we;
    logic [ADDR_W-1:0]             ram_waddr;
    logic [WORD_W-1:0]             ram_wdata;
    logic [ADDR_W-1:0]             ram_raddr;
    logic [WORD_W-1:0]             ram_rdata;

    srdu_pkg::div_req_t            div_req;
    srdu_pkg::div_rsp_t            div_rsp;

    // derived values
    logic [CNT_W-1:0]              count_m1;
    logic [CNT_W-1:0]              count_m2;
    logic [CNT_W-1:0]              roll_src;
    logic [WORD_W-1:0]             roll_dist;
    logic [WORD_W-1:0]             rest_wide;
    logic [WORD_W-1:0]             depth_word;
    logic [ADDR_W-1:0]             ptr_step1;
    logic [ADDR_W-1:0]             ptr_step2;
    logic [WORD_W-1:0]             div_result;
    logic [CNT_W+OCW-1:0]          count_wide;
    logic [CNT_W-1:0]              moves_m1;

    assign count_m1   = count_reg - CNT_W'(1);
    assign count_m2   = count_reg - CNT_W'(2);
    assign roll_dist  = top_reg[WORD_W-1] ? (~top_reg + 1'b1) : top_reg;
    assign rest_wide  = {{(WORD_W-CNT_W){1'b0}}, count_m1};
    // count_m1 is the depth left once n is popped
    assign roll_src   = count_m1 - CNT_W'(1) - roll_dist[CNT_W-1:0];
    assign depth_word = {{(WORD_W-CNT_W){1'b0}}, count_reg};
    assign ptr_step1  = neg_reg ? (ptr_reg - ADDR_W'(1)) : (ptr_reg + ADDR_W'(1));
    assign ptr_step2  = neg_reg ? (ptr_reg - ADDR_W'(2)) : (ptr_reg + ADDR_W'(2));
    assign div_result = (op_reg == srdu_pkg::OP_DIV) ? div_rsp.quotient : div_rsp.remainder;
    assign moves_m1   = moves_reg - CNT_W'(1);

    srdu_ram #(
        .DEPTH  (srdu_pkg::STACK_DEPTH),
        .WIDTH  (WORD_W),
        .ADDR_W (ADDR_W)
    ) u_stack_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    srdu_divider u_divider (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign out_load = (state_reg == ST_DONE) && (!m_valid_reg || m_tready);

    // sequencer
    always_comb
    begin
        state_next   = state_reg;
        op_next      = op_reg;
        val_next     = val_reg;
        count_next   = count_reg;
        top_next     = top_reg;
        status_next  = status_reg;
        word_next    = word_reg;
        popped_next  = popped_reg;
        tmp_next     = tmp_reg;
        ptr_next     = ptr_reg;
        moves_next   = moves_reg;
        neg_next     = neg_reg;

        ram_we       = 1'b0;
        ram_waddr    = '0;
        ram_wdata    = '0;
        ram_raddr    = '0;

        div_req.start    = 1'b0;
        div_req.dividend = ram_rdata;
        div_req.divisor  = top_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    op_next     = s_tuser;
                    val_next    = s_tdata;
                    status_next = srdu_pkg::STAT_OK;
                    popped_next = 1'b0;
                    state_next  = ST_EXEC;
                end
            end

            ST_EXEC:
            begin
                state_next = ST_DONE;
                case (op_reg)
                    srdu_pkg::OP_PUSH,
                    srdu_pkg::OP_DEPTH:
                    begin
                        if (count_reg >= FULL_CNT)
                        begin
                            status_next = srdu_pkg::STAT_OVER;
                        end
                        else
                        begin
                            ram_we     = 1'b1;
                            ram_waddr  = count_reg[ADDR_W-1:0];
                            ram_wdata  = (op_reg == srdu_pkg::OP_PUSH) ? val_reg : depth_word;
                            top_next   = ram_wdata;
                            count_next = count_reg + CNT_W'(1);
                        end
                    end
                    srdu_pkg::OP_POP:
                    begin
                        if (count_reg == '0)
                        begin
                            status_next = srdu_pkg::STAT_UNDER;
                        end
                        else
                        begin
                            // hand out the popped word, then refresh the cached top
                            word_next   = top_reg;
                            popped_next = 1'b1;
                            count_next  = count_m1;
                            if (count_m1 != '0)
                            begin
                                state_next = ST_TOP_RD;
                            end
                        end
                    end
                    srdu_pkg::OP_DIV,
                    srdu_pkg::OP_MOD:
                    begin
                        if (count_reg < CNT_W'(2))
                        begin
                            status_next = srdu_pkg::STAT_UNDER;
                        end
                        else if (top_reg == '0)
                        begin
                            status_next = srdu_pkg::STAT_DIVZ;
                        end
                        else
                        begin
                            state_next = ST_DIV_RD;
                        end
                    end
                    srdu_pkg::OP_ROLL:
                    begin
                        if (count_reg == '0 || roll_dist >= rest_wide)
                        begin
                            status_next = srdu_pkg::STAT_UNDER;
                        end
                        else
                        begin
                            // start at the item that moves: the n-th item, or the top
                            neg_next   = top_reg[WORD_W-1];
                            ptr_next   = top_reg[WORD_W-1] ? count_m2[ADDR_W-1:0]
                                                           : roll_src[ADDR_W-1:0];
                            moves_next = roll_dist[CNT_W-1:0];
                            state_next = ST_ROLL_RD;
                        end
                    end
                    default:
                    begin
                        state_next = ST_DONE;
                    end
                endcase
            end

            ST_DIV_RD:
            begin
                ram_raddr  = count_m2[ADDR_W-1:0];
                state_next = ST_DIV_CAP;
            end

            ST_DIV_CAP:
            begin
                div_req.start = 1'b1;
                state_next    = ST_DIV_WAIT;
            end

            ST_DIV_WAIT:
            begin
                if (div_rsp.done)
                begin
                    ram_we     = 1'b1;
                    ram_waddr  = count_m2[ADDR_W-1:0];
                    ram_wdata  = div_result;
                    top_next   = div_result;
                    count_next = count_m1;
                    state_next = ST_DONE;
                end
            end

            ST_ROLL_RD:
            begin
                ram_raddr  = ptr_reg;
                state_next = ST_ROLL_CAP;
            end

            ST_ROLL_CAP:
            begin
                tmp_next   = ram_rdata;
                state_next = (moves_reg == '0) ? ST_FINAL_WR : ST_MOVE_RD;
            end

            ST_MOVE_RD:
            begin
                ram_raddr  = ptr_step1;
                state_next = ST_MOVE_WR;
            end

            ST_MOVE_WR:
            begin
                // write the neighbor one slot over, fetch the next in the same cycle
                ram_we     = 1'b1;
                ram_waddr  = ptr_reg;
                ram_wdata  = ram_rdata;
                ptr_next   = ptr_step1;
                moves_next = moves_m1;
                if (moves_m1 != '0)
                begin
                    ram_raddr = ptr_step2;
                end
                else
                begin
                    state_next = ST_FINAL_WR;
                end
            end

            ST_FINAL_WR:
            begin
                ram_we     = 1'b1;
                ram_waddr  = ptr_reg;
                ram_wdata  = tmp_reg;
                count_next = count_m1;
                state_next = ST_TOP_RD;
            end

            ST_TOP_RD:
            begin
                ram_raddr  = count_m1[ADDR_W-1:0];
                state_next = ST_TOP_CAP;
            end

            ST_TOP_CAP:
            begin
                top_next   = ram_rdata;
                state_next = ST_DONE;
            end

            ST_DONE:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            count_reg  <= '0;
            popped_reg <= 1'b0;
            moves_reg  <= '0;
            neg_reg    <= 1'b0;
            op_reg     <= '0;
            status_reg <= srdu_pkg::STAT_OK;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            popped_reg <= popped_next;
            moves_reg  <= moves_next;
            neg_reg    <= neg_next;
            op_reg     <= op_next;
            status_reg <= status_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg  <= val_next;
        top_reg  <= top_next;
        word_reg <= word_next;
        tmp_reg  <= tmp_next;
        ptr_reg  <= ptr_next;
    end

    // output register: holds the result beat until taken
    assign count_wide = {{OCW{1'b0}}, count_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            m_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            if (popped_reg)
            begin
                m_word_reg <= word_reg;
                m_flag_reg <= 1'b1;
            end
            else if (count_reg != '0)
            begin
                m_word_reg <= top_reg;
                m_flag_reg <= 1'b1;
            end
            else
            begin
                m_word_reg <= '0;
                m_flag_reg <= 1'b0;
            end
            m_count_reg  <= count_wide[OCW-1:0];
            m_status_reg <= status_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {1'b0, m_count_reg, m_word_reg};
    assign m_tuser  = {m_status_reg, m_flag_reg};

    // ------------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------------
    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) && s_tvalid |=> (state_reg != ST_IDLE))
        else $error("accepted beat did not start the sequencer");

    a_invalid_top_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[0] |-> (m_tdata[31:0] == '0))
        else $error("top_word nonzero while top_valid is low");

    a_div_done_when_waiting: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> (state_reg == ST_DIV_WAIT))
        else $error("divider finished outside the wait state");

    a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |=> (count_reg <= FULL_CNT))
        else $error("entry count exceeds stack depth");

endmodule

// File: hw/rtl/srdu_ram.sv
// ----------------------------------------------------------------------------
// srdu_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data (old data on a same-address collision).
// ----------------------------------------------------------------------------
module srdu_ram #(
    parameter int DEPTH  = 64,
    parameter int WIDTH  = 32,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

// File: hw/rtl/srdu_divider.sv
// ----------------------------------------------------------------------------
// srdu_divider
// Iterative signed divider: one restoring step per cycle on magnitudes, then
// a sign fix-up state. Truncating quotient, remainder takes dividend sign.
// ----------------------------------------------------------------------------
module srdu_divider (
    input  logic               clk,
    input  logic               rst_n,
    input  srdu_pkg::div_req_t req,
    output srdu_pkg::div_rsp_t rsp
);

    localparam logic [1:0] D_IDLE = 2'd0;
    localparam logic [1:0] D_RUN  = 2'd1;
    localparam logic [1:0] D_SIGN = 2'd2;

    logic [1:0]                     dstate_reg;
    logic [srdu_pkg::DIV_CNT_W-1:0] cnt_reg;
    logic [srdu_pkg::WORD_W-1:0]    quo_reg;
    logic [srdu_pkg::WORD_W-1:0]    rem_reg;
    logic [srdu_pkg::WORD_W-1:0]    div_reg;
    logic                           neg_q_reg;
    logic                           neg_r_reg;
    logic                           done_reg;
    logic [srdu_pkg::WORD_W-1:0]    q_out_reg;
    logic [srdu_pkg::WORD_W-1:0]    r_out_reg;

    logic [srdu_pkg::WORD_W-1:0]    a_abs;
    logic [srdu_pkg::WORD_W-1:0]    b_abs;
    logic [srdu_pkg::WORD_W:0]      shifted;
    logic [srdu_pkg::WORD_W:0]      diff;
    logic                           qbit;

    assign a_abs   = req.dividend[srdu_pkg::WORD_W-1] ? (~req.dividend + 1'b1) : req.dividend;
    assign b_abs   = req.divisor[srdu_pkg::WORD_W-1] ? (~req.divisor + 1'b1) : req.divisor;
    assign shifted = {rem_reg, quo_reg[srdu_pkg::WORD_W-1]};
    assign diff    = shifted - {1'b0, div_reg};
    assign qbit    = ~diff[srdu_pkg::WORD_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dstate_reg <= D_IDLE;
            cnt_reg    <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (dstate_reg)
                D_IDLE:
                begin
                    if (req.start)
                    begin
                        dstate_reg <= D_RUN;
                        cnt_reg    <= '0;
                    end
                end
                D_RUN:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == {srdu_pkg::DIV_CNT_W{1'b1}})
                    begin
                        dstate_reg <= D_SIGN;
                    end
                end
                D_SIGN:
                begin
                    dstate_reg <= D_IDLE;
                    done_reg   <= 1'b1;
                end
                default:
                begin
                    dstate_reg <= D_IDLE;
                end
            endcase
        end
    end

    // datapath: load magnitudes, shift one quotient bit a cycle, fix signs
    always_ff @(posedge clk)
    begin
        case (dstate_reg)
            D_IDLE:
            begin
                if (req.start)
                begin
                    quo_reg   <= a_abs;
                    div_reg   <= b_abs;
                    rem_reg   <= '0;
                    neg_q_reg <= req.dividend[srdu_pkg::WORD_W-1]
                               ^ req.divisor[srdu_pkg::WORD_W-1];
                    neg_r_reg <= req.dividend[srdu_pkg::WORD_W-1];
                end
            end
            D_RUN:
            begin
                quo_reg <= {quo_reg[srdu_pkg::WORD_W-2:0], qbit};
                rem_reg <= qbit ? diff[srdu_pkg::WORD_W-1:0]
                                : shifted[srdu_pkg::WORD_W-1:0];
            end
            D_SIGN:
            begin
                q_out_reg <= neg_q_reg ? (~quo_reg + 1'b1) : quo_reg;
                r_out_reg <= neg_r_reg ? (~rem_reg + 1'b1) : rem_reg;
            end
            default:
            begin
                quo_reg <= quo_reg;
            end
        endcase
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = q_out_reg;
    assign rsp.remainder = r_out_reg;

endmodule

// File: dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the data stack unit. It sends operation beats in
// bursts while the result side stalls on a rotating pattern or stays ready. A
// mirror of the stack computes the outcome of every accepted beat, and each
// result beat is compared with the oldest pending outcome. A short directed
// table runs first: empty-stack errors, the most negative word divided by -1,
// zero divisor, roll both ways and roll out of range. Random operation
// sequences follow; they fill and drain the stack across its whole depth.
// ----------------------------------------------------------------------------
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    // unused operation codes: the block ignores them
    localparam logic [srdu_pkg::OP_W-1:0] OP_SPARE6 = 3'd6;
    localparam logic [srdu_pkg::OP_W-1:0] OP_SPARE7 = 3'd7;

    localparam int RANDOM_OPS    = 1800;
    localparam int DRAIN_CYCLES  = 120;
    localparam int DIRECTED_ROWS = 26;

    typedef struct packed {
        logic [31:0] top_word;
        logic        top_valid;
        logic [6:0]  item_count;
        logic [1:0]  status;
    } stack_outcome_t;

    typedef struct packed {
        logic [srdu_pkg::OP_W-1:0] op;
        logic [31:0]               value;
        logic                      pinned;    // outcome typed in below
        stack_outcome_t            outcome;
    } stim_row_t;

    // Directed rows. Pinned rows carry their outcome; the rest use the mirror.
    localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
        // errors on the empty stack
        '{srdu_pkg::OP_POP,   32'h0000_0000, 1'b1, '{32'h0, 1'b0, 7'd0, srdu_pkg::STAT_UNDER}},
        '{srdu_pkg::OP_ROLL,  32'h0000_0000, 1'b1, '{32'h0, 1'b0, 7'd0, srdu_pkg::STAT_UNDER}},
        '{srdu_pkg::OP_DIV,   32'h0000_0000, 1'b1, '{32'h0, 1'b0, 7'd0, srdu_pkg::STAT_UNDER}},
        '{srdu_pkg::OP_MOD,   32'h0000_0000, 1'b1, '{32'h0, 1'b0, 7'd0, srdu_pkg::STAT_UNDER}},
        // depth of an empty stack pushes zero
        '{srdu_pkg::OP_DEPTH, 32'h0000_0000, 1'b1, '{32'h0, 1'b1, 7'd1, srdu_pkg::STAT_OK}},
        '{srdu_pkg::OP_DIV,   32'h0000_0000, 1'b1, '{32'h0, 1'b1, 7'd1, srdu_pkg::STAT_UNDER}},
        '{OP_SPARE7,          32'hFFFF_FFFF, 1'b1, '{32'h0, 1'b1, 7'd1, srdu_pkg::STAT_OK}},
        // most negative word divided by -1 wraps, remainder is zero
        '{srdu_pkg::OP_PUSH,  32'h8000_0000, 1'b1,
          '{32'h8000_0000, 1'b1, 7'd2, srdu_pkg::STAT_OK}},
        '{srdu_pkg::OP_PUSH,  32'hFFFF_FFFF, 1'b1,
          '{32'hFFFF_FFFF, 1'b1, 7'd3, srdu_pkg::STAT_OK}},
        '{srdu_pkg::OP_DIV,   32'h0000_0000, 1'b1,
          '{32'h8000_0000, 1'b1, 7'd2, srdu_pkg::STAT_OK}},
        '{srdu_pkg::OP_PUSH,  32'hFFFF_FFFF, 1'b0, '0},
        '{srdu_pkg::OP_MOD,   32'h0000_0000, 1'b1, '{32'h0, 1'b1, 7'd2, srdu_pkg::STAT_OK}},
        // zero divisor leaves the stack alone
        '{srdu_pkg::OP_DEPTH, 32'h0000_0000, 1'b0, '0},
        '{srdu_pkg::OP_PUSH,  32'h0000_0000, 1'b0, '0},
        '{srdu_pkg::OP_DIV,   32'h0000_0000, 1'b1, '{32'h0, 1'b1, 7'd4, srdu_pkg::STAT_DIVZ}},
        '{srdu_pkg::OP_POP,   32'h0000_0000, 1'b0, '0},
        '{OP_SPARE6,          32'h5555_AAAA, 1'b0, '0},
        // truncating divide of the largest word
        '{srdu_pkg::OP_PUSH,  32'h7FFF_FFFF, 1'b0, '0},
        '{srdu_pkg::OP_PUSH,  32'hFFFF_FFFE, 1'b0, '0},
        '{srdu_pkg::OP_DIV,   32'h0000_0000, 1'b0, '0},
        // roll up from the bottom, then sink back to the bottom
        '{srdu_pkg::OP_PUSH,  32'h0000_0003, 1'b0, '0},
        '{srdu_pkg::OP_ROLL,  32'h0000_0000, 1'b0, '0},
        '{srdu_pkg::OP_PUSH,  32'hFFFF_FFFD, 1'b0, '0},
        '{srdu_pkg::OP_ROLL,  32'h0000_0000, 1'b0, '0},
        // roll deeper than the stack: n stays on top
        '{srdu_pkg::OP_PUSH,  32'h0000_0004, 1'b1, '{32'h4, 1'b1, 7'd5, srdu_pkg::STAT_OK}},
        '{srdu_pkg::OP_ROLL,  32'h0000_0000, 1'b1,
          '{32'h4, 1'b1, 7'd5, srdu_pkg::STAT_UNDER}}
    };

    logic        clk;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;     // [31:0] value
    logic [2:0]  s_tuser = '0;     // [2:0] operation
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;          // [31:0] top_word, [38:32] item_count, [39] zero
    logic [2:0]  m_tuser;          // [0] top_valid, [2:1] status

    // mirror of the stack contents and fill level
    logic [31:0]    mirror_words [srdu_pkg::STACK_DEPTH];
    int             mirror_fill = 0;
    stack_outcome_t outcome_q [$];

    int errors     = 0;
    int ops_run    = 0;
    int burst_left = 1;

    // receiver stall pattern
    logic [15:0] stall_bits  = '1;
    logic [3:0]  stall_phase = '0;
    int          stall_mode  = 0;
    int          stall_left  = 0;

    stack_roll_divide_unit_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Apply one operation to the mirror and return the result beat it causes.
    function automatic stack_outcome_t run_stack_op(input logic [srdu_pkg::OP_W-1:0] op,
                                                    input logic [31:0] value);
        stack_outcome_t res;
        logic [1:0]     status;
        logic [31:0]    popped;
        logic [31:0]    moved;
        longint         num;
        longint         den;
        longint         quo;
        longint         n;
        longint         mag;
        int             rest;
        int             src;
        int             dst;

        status = srdu_pkg::STAT_OK;
        popped = '0;
        case (op)
            srdu_pkg::OP_PUSH, srdu_pkg::OP_DEPTH:
            begin
                if (mirror_fill >= srdu_pkg::STACK_DEPTH)
                    status = srdu_pkg::STAT_OVER;
                else
                begin
                    mirror_words[mirror_fill] = (op == srdu_pkg::OP_PUSH) ? value
                                                                          : 32'(mirror_fill);
                    mirror_fill++;
                end
            end
            srdu_pkg::OP_POP:
            begin
                if (mirror_fill == 0)
                    status = srdu_pkg::STAT_UNDER;
                else
                begin
                    mirror_fill--;
                    popped = mirror_words[mirror_fill];
                end
            end
            srdu_pkg::OP_DIV, srdu_pkg::OP_MOD:
            begin
                if (mirror_fill < 2)
                    status = srdu_pkg::STAT_UNDER;
                else
                begin
                    den = longint'(signed'(mirror_words[mirror_fill - 1]));
                    num = longint'(signed'(mirror_words[mirror_fill - 2]));
                    if (den == 0)
                        status = srdu_pkg::STAT_DIVZ;
                    else
                    begin
                        // 64-bit math truncates toward zero; take the low word
                        quo = (op == srdu_pkg::OP_DIV) ? num / den : num % den;
                        mirror_words[mirror_fill - 2] = quo[31:0];
                        mirror_fill--;
                    end
                end
            end
            srdu_pkg::OP_ROLL:
            begin
                if (mirror_fill == 0)
                    status = srdu_pkg::STAT_UNDER;
                else
                begin
                    n    = longint'(signed'(mirror_words[mirror_fill - 1]));
                    mag  = (n < 0) ? -n : n;
                    rest = mirror_fill - 1;
                    if (mag >= rest)
                        status = srdu_pkg::STAT_UNDER;
                    else
                    begin
                        if (n >= 0)
                        begin
                            src   = rest - 1 - int'(mag);
                            moved = mirror_words[src];
                            for (int i = src; i < rest - 1; i++)
                                mirror_words[i] = mirror_words[i + 1];
                            mirror_words[rest - 1] = moved;
                        end
                        else
                        begin
                            dst   = rest - 1 - int'(mag);
                            moved = mirror_words[rest - 1];
                            for (int i = rest - 1; i > dst; i--)
                                mirror_words[i] = mirror_words[i - 1];
                            mirror_words[dst] = moved;
                        end
                        mirror_fill = rest;
                    end
                end
            end
            default: ;
        endcase

        if (op == srdu_pkg::OP_POP && status == srdu_pkg::STAT_OK)
        begin
            res.top_word  = popped;
            res.top_valid = 1'b1;
        end
        else if (mirror_fill > 0)
        begin
            res.top_word  = mirror_words[mirror_fill - 1];
            res.top_valid = 1'b1;
        end
        else
        begin
            res.top_word  = '0;
            res.top_valid = 1'b0;
        end
        res.item_count = 7'(mirror_fill);
        res.status     = status;
        return res;
    endfunction

    // Mostly extremes and small numbers, the rest fully random.
    function automatic logic [31:0] rand_word();
        int pick;

        pick = $urandom_range(0, 9);
        case (pick)
            0:       return 32'h0000_0000;
            1:       return 32'h8000_0000;
            2:       return 32'h7FFF_FFFF;
            3:       return 32'hFFFF_FFFF;
            4, 5, 6: return 32'($signed($urandom_range(0, 40)) - 20);
            default: return $urandom();
        endcase
    endfunction

    // Drive one beat, hold it until accepted, then log its outcome. Drop valid
    // for a random gap at the end of each burst.
    task automatic issue_op(input logic [srdu_pkg::OP_W-1:0] op, input logic [31:0] value,
                            input logic pinned, input stack_outcome_t pinned_outcome);
        stack_outcome_t outcome;

        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= value;
        do
            @(posedge clk);
        while (!s_tready);

        outcome = run_stack_op(op, value);
        outcome_q.push_back(pinned ? pinned_outcome : outcome);
        if (op <= srdu_pkg::OP_DEPTH)
            ops_run++;

        burst_left--;
        if (burst_left <= 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? 48 : $urandom_range(1, 10);
        end
    endtask

    initial
    begin : stimulus
        int          mode;
        int          mode_left;
        int          pick;
        int          push_cut;
        int          pop_cut;
        int          depth_cut;
        int          span;
        logic [31:0] num;
        logic [31:0] den;
        logic [31:0] roll_n;

        mode      = 2;
        mode_left = 0;
        wait (rst_n);
        @(posedge clk);

        foreach (DIRECTED[i])
            issue_op(DIRECTED[i].op, DIRECTED[i].value, DIRECTED[i].pinned,
                     DIRECTED[i].outcome);

        while (ops_run < RANDOM_OPS)
        begin
            // Switch among fill, drain and mixed phases so the stack level
            // sweeps from empty to full and back.
            if (mode_left == 0)
            begin
                mode      = $urandom_range(0, 2);
                mode_left = $urandom_range(20, 80);
            end
            mode_left--;
            case (mode)
                0:       begin push_cut = 45; pop_cut = 50; depth_cut = 60; end
                1:       begin push_cut = 5;  pop_cut = 55; depth_cut = 58; end
                default: begin push_cut = 25; pop_cut = 50; depth_cut = 55; end
            endcase

            pick = $urandom_range(0, 99);
            if (pick < push_cut)
                issue_op(srdu_pkg::OP_PUSH, rand_word(), 1'b0, '0);
            else if (pick < pop_cut)
                issue_op(srdu_pkg::OP_POP, $urandom(), 1'b0, '0);
            else if (pick < depth_cut)
                issue_op(srdu_pkg::OP_DEPTH, $urandom(), 1'b0, '0);
            else if (pick < depth_cut + 20)
            begin
                // dividend, divisor, then divide or modulo
                num = rand_word();
                den = rand_word();
                case ($urandom_range(0, 9))
                    0:       den = '0;
                    1:       begin num = 32'h8000_0000; den = '1; end
                    default: ;
                endcase
                issue_op(srdu_pkg::OP_PUSH, num, 1'b0, '0);
                issue_op(srdu_pkg::OP_PUSH, den, 1'b0, '0);
                issue_op($urandom_range(0, 1) ? srdu_pkg::OP_MOD : srdu_pkg::OP_DIV,
                         $urandom(), 1'b0, '0);
            end
            else if (pick < depth_cut + 32)
            begin
                // push a roll count that mostly fits the stack, then roll
                if (mirror_fill > 0)
                begin
                    span = mirror_fill - 1;
                    case ($urandom_range(0, 7))
                        0:       roll_n = 32'(mirror_fill);
                        1, 2:    roll_n = 32'(span);
                        default: roll_n = 32'($urandom_range(0, span));
                    endcase
                    if ($urandom_range(0, 1))
                        roll_n = -roll_n;
                    issue_op(srdu_pkg::OP_PUSH, roll_n, 1'b0, '0);
                end
                issue_op(srdu_pkg::OP_ROLL, $urandom(), 1'b0, '0);
            end
            else
                issue_op(3'($urandom_range(0, 7)), rand_word(), 1'b0, '0);
        end

        if (burst_left > 0)
            s_tvalid <= 1'b0;
        while (outcome_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // Receiver: either always ready or stalling on a rotating 16-bit pattern.
    // Bit 0 is forced so no stall lasts a full turn of the pattern.
    always @(posedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode = $urandom_range(0, 2);
            stall_bits = 16'($urandom()) | 16'h0001;
            stall_left = $urandom_range(16, 96);
        end
        stall_left--;
        stall_phase++;
        m_tready <= (stall_mode == 0) ? 1'b1 : stall_bits[stall_phase];
    end

    // Compare every accepted result beat with the oldest pending outcome.
    always @(posedge clk)
    begin : check_results
        stack_outcome_t want;

        if (rst_n && m_tvalid && m_tready)
        begin
            if (outcome_q.size() == 0)
            begin
                $error("result beat with nothing pending: tdata %h tuser %h",
                       m_tdata, m_tuser);
                errors++;
            end
            else
            begin
                want = outcome_q.pop_front();
                if (m_tdata[31:0] !== want.top_word)
                begin
                    $error("top_word: expected %h, got %h", want.top_word, m_tdata[31:0]);
                    errors++;
                end
                if (m_tuser[0] !== want.top_valid)
                begin
                    $error("top_valid: expected %b, got %b", want.top_valid, m_tuser[0]);
                    errors++;
                end
                if (m_tdata[38:32] !== want.item_count)
                begin
                    $error("item_count: expected %0d, got %0d", want.item_count,
                           m_tdata[38:32]);
                    errors++;
                end
                if (m_tuser[2:1] !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, m_tuser[2:1]);
                    errors++;
                end
            end
        end
    end

    // Hard stop well past the slowest correct run.
    initial
    begin
        #15_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
